// File: sv/sawct_pkg.sv
`timescale 1ns / 1ps

package sawct_pkg;

   // Default geometry
   localparam int DEF_ADDRESS_BITS = 23;
   localparam int DEF_OFFSET_BITS  = 10;
   localparam int DEF_SET_BITS     = 3;
   localparam int DEF_WAY_COUNT    = 2;

   // Fixed field widths on the ports
   localparam int CMD_W         = 1;
   localparam int ADDRESS_W     = 23;
   localparam int WAY_W         = 1;
   localparam int SET_INDEX_W   = 3;
   localparam int LINE_OFFSET_W = 10;
   localparam int LINE_NUM_W    = 13;

   // Internal working width for addresses and line numbers
   localparam int WORK_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

endpackage

// File: sv/set_assoc_writeback_cache_tags_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_cmd, req_address
// rsp_      out        rsp_valid / rsp_ready  rsp_hit, rsp_way, rsp_set_index,
//                                             rsp_line_offset, rsp_writeback,
//                                             rsp_writeback_line, rsp_fill,
//                                             rsp_fill_line
//
// One request a cycle unless the result stalls: an input register, then the tag
// compare, victim choice and state update in one pass into the result register.
// Throughput is set by that single pass over the tag row of the addressed set.
// Reset clears valid, dirty and most-recent-way bits; tags are written on fill.
// A stalled result holds the result register and the request behind it; the
// input stage takes a request while it is empty or the stage ahead can move.

module set_assoc_writeback_cache_tags_core #(
   parameter int ADDRESS_BITS = sawct_pkg::DEF_ADDRESS_BITS,
   parameter int OFFSET_BITS  = sawct_pkg::DEF_OFFSET_BITS,
   parameter int SET_BITS     = sawct_pkg::DEF_SET_BITS,
   parameter int WAY_COUNT    = sawct_pkg::DEF_WAY_COUNT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sawct_pkg::CMD_W-1:0]            req_cmd,
   input  logic [sawct_pkg::ADDRESS_W-1:0]        req_address,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [sawct_pkg::WAY_W-1:0]            rsp_way,
   output logic [sawct_pkg::SET_INDEX_W-1:0]      rsp_set_index,
   output logic [sawct_pkg::LINE_OFFSET_W-1:0]    rsp_line_offset,
   output logic                                   rsp_writeback,
   output logic [sawct_pkg::LINE_NUM_W-1:0]       rsp_writeback_line,
   output logic                                   rsp_fill,
   output logic [sawct_pkg::LINE_NUM_W-1:0]       rsp_fill_line
);

   import sawct_pkg::*;

   localparam int TAG_BITS  = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
   localparam int LINE_W    = ADDRESS_BITS - OFFSET_BITS;
   localparam int SET_COUNT = 1 << SET_BITS;
   localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_IDX_W = $clog2(WAY_COUNT);

   localparam logic [WORK_W-1:0] ADDR_MASK =
      (ADDRESS_BITS >= WORK_W) ? {WORK_W{1'b1}} : WORK_W'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [WORK_W-1:0] OFFSET_MASK = WORK_W'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [WORK_W-1:0] LINE_MASK   = WORK_W'((64'd1 << LINE_W) - 64'd1);
   localparam logic [WORK_W-1:0] SET_MASK    = WORK_W'((64'd1 << SET_BITS) - 64'd1);
   localparam logic [WAY_IDX_W-1:0] LAST_WAY = WAY_IDX_W'(WAY_COUNT - 1);

   // Input stage
   logic                  in_valid_ff, in_valid_in;
   cmd_type               in_cmd_ff, in_cmd_in;
   logic [ADDRESS_W-1:0]  in_address_ff, in_address_in;

   // Cache state
   logic [TAG_BITS-1:0]   tag_ff   [SET_COUNT][WAY_COUNT];
   logic [TAG_BITS-1:0]   tag_in   [SET_COUNT][WAY_COUNT];
   logic [WAY_COUNT-1:0]  valid_ff [SET_COUNT];
   logic [WAY_COUNT-1:0]  valid_in [SET_COUNT];
   logic [WAY_COUNT-1:0]  dirty_ff [SET_COUNT];
   logic [WAY_COUNT-1:0]  dirty_in [SET_COUNT];
   logic [WAY_IDX_W-1:0]  recent_ff [SET_COUNT];
   logic [WAY_IDX_W-1:0]  recent_in [SET_COUNT];

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic [WAY_W-1:0]          rsp_way_ff, rsp_way_in;
   logic [SET_INDEX_W-1:0]    rsp_set_index_ff, rsp_set_index_in;
   logic [LINE_OFFSET_W-1:0]  rsp_line_offset_ff, rsp_line_offset_in;
   logic                      rsp_writeback_ff, rsp_writeback_in;
   logic [LINE_NUM_W-1:0]     rsp_writeback_line_ff, rsp_writeback_line_in;
   logic                      rsp_fill_ff, rsp_fill_in;
   logic [LINE_NUM_W-1:0]     rsp_fill_line_ff, rsp_fill_line_in;

   // Lookup
   logic                  advance;
   logic [WORK_W-1:0]     addr_w;
   logic [WORK_W-1:0]     line_w;
   logic [WORK_W-1:0]     set_w;
   logic [SET_IDX_W-1:0]  set_idx;
   logic [TAG_BITS-1:0]   req_tag;
   logic                  hit;
   logic [WAY_IDX_W-1:0]  hit_way;
   logic [WAY_IDX_W-1:0]  victim;
   logic [WAY_IDX_W-1:0]  sel;
   logic                  victim_dirty;
   logic [WORK_W-1:0]     victim_line_w;
   logic                  is_write;

   // The lookup stage moves when the result register is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_cmd_in     = in_cmd_ff;
      in_address_in = in_address_ff;
      if (req_ready) begin
         in_valid_in   = req_valid;
         in_cmd_in     = cmd_type'(req_cmd);
         in_address_in = req_address;
      end
   end

   // Address split: tag | set | offset
   always_comb begin
      addr_w  = WORK_W'(in_address_ff) & ADDR_MASK;
      line_w  = (addr_w >> OFFSET_BITS) & LINE_MASK;
      set_w   = line_w & SET_MASK;
      set_idx = SET_IDX_W'(set_w);
      req_tag = TAG_BITS'(line_w >> SET_BITS);
   end

   // Tag compare across the row; the lowest matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (!hit && valid_ff[set_idx][w] && (tag_ff[set_idx][w] == req_tag)) begin
            hit     = 1'b1;
            hit_way = WAY_IDX_W'(w);
         end
      end
   end

   // Round-robin victim: the way after the most recently used one
   always_comb begin
      if (recent_ff[set_idx] == LAST_WAY) begin
         victim = '0;
      end else begin
         victim = recent_ff[set_idx] + WAY_IDX_W'(1);
      end
      sel           = hit ? hit_way : victim;
      victim_dirty  = valid_ff[set_idx][victim] && dirty_ff[set_idx][victim];
      victim_line_w = ((WORK_W'(tag_ff[set_idx][victim]) << SET_BITS) | set_w) & LINE_MASK;
      is_write      = (in_cmd_ff == CMD_WRITE);
   end

   // State update, done as the request passes into the result register
   always_comb begin
      tag_in    = tag_ff;
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      recent_in = recent_ff;
      if (in_valid_ff && advance) begin
         recent_in[set_idx] = sel;
         if (hit) begin
            if (is_write) begin
               dirty_in[set_idx][sel] = 1'b1;
            end
         end else begin
            tag_in[set_idx][sel]   = req_tag;
            valid_in[set_idx][sel] = 1'b1;
            dirty_in[set_idx][sel] = is_write;
         end
      end
   end

   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_hit_in            = rsp_hit_ff;
      rsp_way_in            = rsp_way_ff;
      rsp_set_index_in      = rsp_set_index_ff;
      rsp_line_offset_in    = rsp_line_offset_ff;
      rsp_writeback_in      = rsp_writeback_ff;
      rsp_writeback_line_in = rsp_writeback_line_ff;
      rsp_fill_in           = rsp_fill_ff;
      rsp_fill_line_in      = rsp_fill_line_ff;
      if (advance) begin
         rsp_valid_in          = in_valid_ff;
         rsp_hit_in            = hit;
         rsp_way_in            = WAY_W'(sel);
         rsp_set_index_in      = SET_INDEX_W'(set_w);
         rsp_line_offset_in    = LINE_OFFSET_W'(addr_w & OFFSET_MASK);
         rsp_writeback_in      = !hit && victim_dirty;
         rsp_writeback_line_in = (!hit && victim_dirty) ? LINE_NUM_W'(victim_line_w) : '0;
         rsp_fill_in           = !hit;
         rsp_fill_line_in      = hit ? '0 : LINE_NUM_W'(line_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SET_COUNT; s++) begin
            valid_ff[s]  <= '0;
            dirty_ff[s]  <= '0;
            recent_ff[s] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         recent_ff    <= recent_in;
      end
   end

   // Payload registers and tags carry no reset
   always_ff @(posedge clock) begin
      in_cmd_ff             <= in_cmd_in;
      in_address_ff         <= in_address_in;
      tag_ff                <= tag_in;
      rsp_hit_ff            <= rsp_hit_in;
      rsp_way_ff            <= rsp_way_in;
      rsp_set_index_ff      <= rsp_set_index_in;
      rsp_line_offset_ff    <= rsp_line_offset_in;
      rsp_writeback_ff      <= rsp_writeback_in;
      rsp_writeback_line_ff <= rsp_writeback_line_in;
      rsp_fill_ff           <= rsp_fill_in;
      rsp_fill_line_ff      <= rsp_fill_line_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_way            = rsp_way_ff;
   assign rsp_set_index      = rsp_set_index_ff;
   assign rsp_line_offset    = rsp_line_offset_ff;
   assign rsp_writeback      = rsp_writeback_ff;
   assign rsp_writeback_line = rsp_writeback_line_ff;
   assign rsp_fill           = rsp_fill_ff;
   assign rsp_fill_line      = rsp_fill_line_ff;

endmodule

// File: test/set_assoc_writeback_cache_tags_core_tb.sv
`timescale 1ns / 1ps

module set_assoc_writeback_cache_tags_core_tb;

   import sawct_pkg::*;

   // Geometry as built by the default parameters
   localparam int OFFSET_W    = DEF_OFFSET_BITS;
   localparam int SET_W       = DEF_SET_BITS;
   localparam int TAG_W       = DEF_ADDRESS_BITS - DEF_OFFSET_BITS - DEF_SET_BITS;
   localparam int SET_COUNT   = 1 << DEF_SET_BITS;
   localparam int WAYS        = DEF_WAY_COUNT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic                     hit;
      logic [WAY_W-1:0]         way;
      logic [SET_INDEX_W-1:0]   set_index;
      logic [LINE_OFFSET_W-1:0] line_offset;
      logic                     writeback;
      logic [LINE_NUM_W-1:0]    writeback_line;
      logic                     fill;
      logic [LINE_NUM_W-1:0]    fill_line;
   } lookup_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd     = CMD_READ;
   logic [ADDRESS_W-1:0]     req_address = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   logic                     rsp_hit;
   logic [WAY_W-1:0]         rsp_way;
   logic [SET_INDEX_W-1:0]   rsp_set_index;
   logic [LINE_OFFSET_W-1:0] rsp_line_offset;
   logic                     rsp_writeback;
   logic [LINE_NUM_W-1:0]    rsp_writeback_line;
   logic                     rsp_fill;
   logic [LINE_NUM_W-1:0]    rsp_fill_line;

   // Shadow of the cache bookkeeping, updated in acceptance order
   logic [TAG_W-1:0] way_tag   [SET_COUNT][WAYS] = '{default: '0};
   logic             way_valid [SET_COUNT][WAYS] = '{default: 1'b0};
   logic             way_dirty [SET_COUNT][WAYS] = '{default: 1'b0};
   logic [WAY_W-1:0] mru_way   [SET_COUNT]       = '{default: '0};

   lookup_type       pending_lookups [$];
   int               error_count   = 0;
   int               cycle_count   = 0;
   bit               source_steady = 1'b0;
   bit               sink_steady   = 1'b0;
   int               hold_request  = 0;
   int               stall_left    = 0;
   logic [TAG_W-1:0] tag_pool [3]  = '{10'h000, 10'h3FF, 10'h155};

   set_assoc_writeback_cache_tags_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_way            (rsp_way),
      .rsp_set_index      (rsp_set_index),
      .rsp_line_offset    (rsp_line_offset),
      .rsp_writeback      (rsp_writeback),
      .rsp_writeback_line (rsp_writeback_line),
      .rsp_fill           (rsp_fill),
      .rsp_fill_line      (rsp_fill_line)
   );

   always #1 clock = ~clock;

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** set_assoc_writeback_cache_tags_core: FAILED **");
         $finish;
      end
   end

   // Mostly short idles, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [ADDRESS_W-1:0] make_addr(logic [TAG_W-1:0] tag,
                                                      logic [SET_INDEX_W-1:0] set_sel,
                                                      logic [LINE_OFFSET_W-1:0] offset);
      return {tag, set_sel, offset};
   endfunction

   // Tags mostly from a small pool so that sets see hits, reuse and
   // dirty evictions; the odd fresh tag keeps every tag bit moving.
   function automatic logic [ADDRESS_W-1:0] pick_address();
      logic [TAG_W-1:0] tag;
      if ($urandom_range(0, 9) < 8)
         tag = tag_pool[$urandom_range(0, 2)];
      else
         tag = TAG_W'($urandom);
      return make_addr(tag, SET_INDEX_W'($urandom), LINE_OFFSET_W'($urandom));
   endfunction

   // Tag lookup as the cache performs it: compare, then on a miss evict the
   // way after the most recent one and install the new tag there.
   function automatic lookup_type tag_lookup(cmd_type cmd, logic [ADDRESS_W-1:0] addr);
      lookup_type             r;
      logic [SET_INDEX_W-1:0] set_sel;
      logic [TAG_W-1:0]       tag;
      logic [WAY_W-1:0]       victim;
      int                     w;
      r           = '0;
      set_sel     = addr[OFFSET_W +: SET_W];
      tag         = addr[ADDRESS_W-1 -: TAG_W];
      r.set_index   = set_sel;
      r.line_offset = addr[OFFSET_W-1:0];
      for (w = 0; w < WAYS; w++) begin
         if (!r.hit && way_valid[set_sel][w] && way_tag[set_sel][w] == tag) begin
            r.hit = 1'b1;
            r.way = WAY_W'(w);
         end
      end
      if (r.hit) begin
         mru_way[set_sel] = r.way;
         if (cmd == CMD_WRITE)
            way_dirty[set_sel][r.way] = 1'b1;
      end else begin
         victim = WAY_W'((int'(mru_way[set_sel]) + 1) % WAYS);
         if (way_valid[set_sel][victim] && way_dirty[set_sel][victim]) begin
            r.writeback      = 1'b1;
            r.writeback_line = {way_tag[set_sel][victim], set_sel};
         end
         way_tag[set_sel][victim]   = tag;
         way_valid[set_sel][victim] = 1'b1;
         way_dirty[set_sel][victim] = (cmd == CMD_WRITE);
         mru_way[set_sel]           = victim;
         r.way       = victim;
         r.fill      = 1'b1;
         r.fill_line = addr[ADDRESS_W-1:OFFSET_W];
      end
      return r;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(string name, logic [LINE_NUM_W-1:0] got,
                              logic [LINE_NUM_W-1:0] want);
      if (got !== want)
         report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   // Predict at request acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_lookups.push_back(tag_lookup(cmd_type'(req_cmd), req_address));
   end

   // Check at response acceptance
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            report_error($sformatf("response with no request outstanding, set %0d",
                                   rsp_set_index));
         end else begin
            want = pending_lookups.pop_front();
            check_field("hit",            rsp_hit,            want.hit);
            check_field("way",            rsp_way,            want.way);
            check_field("set_index",      rsp_set_index,      want.set_index);
            check_field("line_offset",    rsp_line_offset,    want.line_offset);
            check_field("writeback",      rsp_writeback,      want.writeback);
            check_field("writeback_line", rsp_writeback_line, want.writeback_line);
            check_field("fill",           rsp_fill,           want.fill);
            check_field("fill_line",      rsp_fill_line,      want.fill_line);
         end
      end
   end

   // Response sink: random stalls, or a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (hold_request != 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (sink_steady || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left = pick_gap() - 1;
      end
   end

   // One request; valid is only dropped when an idle gap is wanted, so a
   // back-to-back request never sees valid lowered and raised in one step.
   task automatic send_request(cmd_type cmd, logic [ADDRESS_W-1:0] addr);
      int gap;
      gap = (source_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random();
      send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, pick_address());
   endtask

   // Extremes of the address, every command, hits both ways, misses into
   // invalid, clean and dirty victims.
   task automatic test_directed();
      send_request(CMD_READ,  23'h000000);                       // cold miss
      send_request(CMD_READ,  23'h000000);                       // read hit
      send_request(CMD_WRITE, 23'h7FFFFF);                       // top tag, set, offset
      send_request(CMD_WRITE, make_addr(10'h3FF, 3'd7, 10'h000)); // write hit
      send_request(CMD_READ,  make_addr(10'h001, 3'd7, 10'h200)); // miss into invalid way
      send_request(CMD_READ,  make_addr(10'h002, 3'd7, 10'h155)); // dirty all-ones line out
      // set 2: fill both ways, evict clean, dirty a line, evict it
      send_request(CMD_READ,  make_addr(10'h011, 3'd2, 10'h001));
      send_request(CMD_READ,  make_addr(10'h022, 3'd2, 10'h002));
      send_request(CMD_READ,  make_addr(10'h033, 3'd2, 10'h004)); // clean victim
      send_request(CMD_WRITE, make_addr(10'h033, 3'd2, 10'h008)); // dirty on hit
      send_request(CMD_READ,  make_addr(10'h044, 3'd2, 10'h010));
      send_request(CMD_READ,  make_addr(10'h055, 3'd2, 10'h020)); // dirty victim
      send_request(CMD_WRITE, make_addr(10'h044, 3'd2, 10'h040));
      send_request(CMD_WRITE, make_addr(10'h066, 3'd2, 10'h080)); // write miss
      send_request(CMD_READ,  make_addr(10'h044, 3'd2, 10'h100)); // hit in way 0
      send_request(CMD_READ,  make_addr(10'h077, 3'd2, 10'h3FF)); // write-miss line out
      send_request(CMD_READ,  23'h555555);
      send_request(CMD_WRITE, 23'h2AAAAA);
   endtask

   // A stretch with neither side idling
   task automatic test_streaming();
      source_steady = 1'b1;
      sink_steady   = 1'b1;
      repeat (60) send_random();
      source_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   // Sets churned through a small, drifting tag pool
   task automatic test_set_churn();
      for (int i = 0; i < 350; i++) begin
         if (i % 50 == 49)
            tag_pool[$urandom_range(0, 2)] = TAG_W'($urandom);
         send_random();
      end
   endtask

   // Sink holds off for a long stretch while requests keep coming, so the
   // pipeline fills and req_ready has to fall.
   task automatic test_backpressure();
      hold_request  = 80;
      source_steady = 1'b1;
      repeat (40) send_random();
      source_steady = 1'b0;
   endtask

   // Addresses and commands over the full range
   task automatic test_wide_random();
      repeat (80) send_request($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                               ADDRESS_W'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_streaming();
      test_set_churn();
      test_backpressure();
      test_wide_random();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      // two-stage pipe: a few more cycles catch any stray response
      repeat (6) @(posedge clock);

      if (error_count == 0)
         $display("** set_assoc_writeback_cache_tags_core: PASSED **");
      else
         $display("** set_assoc_writeback_cache_tags_core: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
sv/sawct_pkg.sv
sv/set_assoc_writeback_cache_tags_core.sv
test/set_assoc_writeback_cache_tags_core_tb.sv
